// ===== design/sshb_pkg.sv =====
// ----------------------------------------------------------------------------
// sshb_pkg: shared types and constants for the sorted-stream histogram binner
// Item structs, register indexes, controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package sshb_pkg;

  // field widths
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 48;
  localparam int BIN_NUM_W  = 6;
  localparam int NBINS_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // bin count limit default
  localparam int DEF_MAX_BINS = 64;

  // iterative divider: one quotient bit per cycle over the key width
  localparam int DIV_CNT_W = $clog2(KEY_W);

  // register reset values
  localparam logic [KEY_W-1:0]   MIN_KEY_RST  = '0;
  localparam logic [KEY_W-1:0]   MAX_KEY_RST  = '1;
  localparam logic [NBINS_W-1:0] NUM_BINS_RST = NBINS_W'(64);

  // saturation limit of all sums
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_KEY  = 2'd0,
    REG_MAX_KEY  = 2'd1,
    REG_NUM_BINS = 2'd2
  } cfg_reg_t;

  // one input item
  typedef struct packed {
    logic [KEY_W-1:0] point_key;
    logic [VAL_W-1:0] point_value;
    logic             last_point;
  } point_t;

  // one result item
  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin_number;
    logic [KEY_W-1:0]     bin_low_key;
    logic [KEY_W-1:0]     bin_high_key;
    logic [SUM_W-1:0]     bin_total;
    logic                 final_bin;
    logic [SUM_W-1:0]     largest_bin_total;
    logic [SUM_W-1:0]     grand_total;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic div_start;  // start bin-width division
    logic restart;    // reload histogram state from registers
    logic load_item;  // capture the accepted item
    logic emit;       // report current bin and advance
    logic add;        // add item value to current bin
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_hit;      // register write this cycle
    logic div_busy;
    logic div_done;
    logic slot_free;    // result register can take a new item
    logic key_ge_min;
    logic key_gt_high;
    logic bins_done;
    logic item_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/sshb_div.sv =====
// ----------------------------------------------------------------------------
// sshb_div: iterative bin-width divider
// Restoring division of the key span by the bin count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sshb_div #(
  parameter int MAX_BINS = sshb_pkg::DEF_MAX_BINS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [sshb_pkg::KEY_W-1:0] dividend,
  input  wire logic [$clog2(MAX_BINS+1)-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [sshb_pkg::KEY_W-1:0]      quot,
  output logic [$clog2(MAX_BINS+1)-1:0]   rem
);

  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int KW    = sshb_pkg::KEY_W;
  localparam int DCW   = sshb_pkg::DIV_CNT_W;

  logic [DCW-1:0] count;
  logic [CNT_W:0] trial;
  logic [CNT_W:0] trial_diff;
  logic           trial_ge;

  // partial remainder with next dividend bit shifted in
  always_comb begin
    trial      = {rem, quot[KW-1]};
    trial_ge   = trial >= {1'b0, divisor};
    trial_diff = trial - {1'b0, divisor};
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + DCW'(1);
        if (count == DCW'(KW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient/remainder shift
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[KW-2:0], trial_ge};
      rem  <= trial_ge ? CNT_W'(trial_diff) : CNT_W'(trial);
    end
  end

endmodule

`default_nettype wire

// ===== design/sshb_datapath.sv =====
// ----------------------------------------------------------------------------
// sshb_datapath: registers, bin bounds, sums and result register
// Bounds advance incrementally: edge(k+1) = edge(k) + q + carry(frac).
// ----------------------------------------------------------------------------
`default_nettype none

module sshb_datapath #(
  parameter int MAX_BINS = sshb_pkg::DEF_MAX_BINS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [sshb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sshb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire sshb_pkg::point_t               point,
  input  wire logic                           bin_ready,
  output logic                                bin_valid,
  output sshb_pkg::result_t                   bin,
  input  wire sshb_pkg::cmd_t                 cmd,
  output sshb_pkg::sts_t                      sts
);

  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int KW    = sshb_pkg::KEY_W;
  localparam int VW    = sshb_pkg::VAL_W;
  localparam int SW    = sshb_pkg::SUM_W;
  localparam int NBW   = sshb_pkg::NBINS_W;
  localparam int BNW   = sshb_pkg::BIN_NUM_W;

  // configuration registers
  logic [KW-1:0]  min_key;
  logic [KW-1:0]  max_key;
  logic [NBW-1:0] num_bins;

  // effective config
  logic [KW-1:0]    eff_max;
  logic [KW-1:0]    span;
  logic [CNT_W-1:0] n_eff;
  logic             cfg_hit;

  // divider
  logic             div_busy;
  logic             div_done;
  logic [KW-1:0]    div_quot;
  logic [CNT_W-1:0] div_rem;

  // held item
  logic [KW-1:0] item_key;
  logic [VW-1:0] item_value;
  logic          item_last;

  // histogram state
  logic [CNT_W-1:0] current_bin;
  logic [KW-1:0]    bin_low;
  logic [KW-1:0]    bin_high;
  logic [CNT_W-1:0] frac;
  logic [SW-1:0]    bin_sum;
  logic [SW-1:0]    run_max;
  logic [SW-1:0]    run_total;
  logic             bins_done;

  // next-value helpers
  logic             is_final;
  logic [SW-1:0]    new_max;
  logic [SW:0]      total_sum;
  logic [SW-1:0]    new_total;
  logic [SW:0]      add_sum;
  logic [SW-1:0]    new_bin_sum;
  logic [CNT_W:0]   frac_sum;
  logic             frac_carry;
  logic [CNT_W-1:0] frac_adv;
  logic [KW-1:0]    high_adv;
  sshb_pkg::result_t payload;

  // clamp registers to their usable range
  always_comb begin
    eff_max = (max_key < min_key) ? min_key : max_key;
    span    = eff_max - min_key;
    if (num_bins == '0) begin
      n_eff = CNT_W'(1);
    end else if (num_bins > NBW'(MAX_BINS)) begin
      n_eff = CNT_W'(MAX_BINS);
    end else begin
      n_eff = CNT_W'(num_bins);
    end
    cfg_hit = cfg_we && (cfg_index inside {sshb_pkg::REG_MIN_KEY, sshb_pkg::REG_MAX_KEY,
                                           sshb_pkg::REG_NUM_BINS});
  end

  sshb_div #(
    .MAX_BINS(MAX_BINS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (span),
    .divisor  (n_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // sums, final-bin test and next bound
  always_comb begin
    is_final    = ({1'b0, current_bin} + (CNT_W+1)'(1)) >= {1'b0, n_eff};
    new_max     = (bin_sum > run_max) ? bin_sum : run_max;
    total_sum   = {1'b0, run_total} + {1'b0, bin_sum};
    new_total   = total_sum[SW] ? sshb_pkg::SUM_MAX : total_sum[SW-1:0];
    add_sum     = {1'b0, bin_sum} + (SW+1)'(item_value);
    new_bin_sum = add_sum[SW] ? sshb_pkg::SUM_MAX : add_sum[SW-1:0];
    frac_sum    = {1'b0, frac} + {1'b0, div_rem};
    frac_carry  = frac_sum >= {1'b0, n_eff};
    frac_adv    = frac_carry ? CNT_W'(frac_sum - {1'b0, n_eff}) : CNT_W'(frac_sum);
    high_adv    = bin_high + div_quot + KW'(frac_carry);

    payload.bin_number        = BNW'(current_bin);
    payload.bin_low_key       = bin_low;
    payload.bin_high_key      = bin_high;
    payload.bin_total         = bin_sum;
    payload.final_bin         = is_final;
    payload.largest_bin_total = is_final ? new_max : '0;
    payload.grand_total       = is_final ? new_total : '0;
  end

  // status to controller
  always_comb begin
    sts.cfg_hit     = cfg_hit;
    sts.div_busy    = div_busy;
    sts.div_done    = div_done;
    sts.slot_free   = !bin_valid || bin_ready;
    sts.key_ge_min  = item_key >= min_key;
    sts.key_gt_high = item_key > bin_high;
    sts.bins_done   = bins_done;
    sts.item_last   = item_last;
  end

  // control state: registers, bin counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      min_key     <= sshb_pkg::MIN_KEY_RST;
      max_key     <= sshb_pkg::MAX_KEY_RST;
      num_bins    <= sshb_pkg::NUM_BINS_RST;
      current_bin <= '0;
      bins_done   <= 1'b0;
      bin_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sshb_pkg::REG_MIN_KEY:  min_key  <= KW'(cfg_data);
          sshb_pkg::REG_MAX_KEY:  max_key  <= KW'(cfg_data);
          sshb_pkg::REG_NUM_BINS: num_bins <= NBW'(cfg_data);
          default: ;
        endcase
      end

      if (cfg_hit || cmd.restart) begin
        current_bin <= '0;
        bins_done   <= 1'b0;
      end else if (cmd.emit) begin
        if (is_final) begin
          bins_done <= 1'b1;
        end else begin
          current_bin <= current_bin + CNT_W'(1);
        end
      end

      if (cmd.emit) begin
        bin_valid <= 1'b1;
      end else if (bin_ready) begin
        bin_valid <= 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_key   <= point.point_key;
      item_value <= point.point_value;
      item_last  <= point.last_point;
    end
  end

  // bounds and sums
  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      bin_low   <= min_key;
      bin_high  <= min_key + div_quot;
      frac      <= div_rem;
      bin_sum   <= '0;
      run_max   <= '0;
      run_total <= '0;
    end else if (cmd.emit) begin
      bin_sum   <= '0;
      run_max   <= new_max;
      run_total <= new_total;
      if (!is_final) begin
        bin_low  <= bin_high;
        bin_high <= high_adv;
        frac     <= frac_adv;
      end
    end else if (cmd.add) begin
      bin_sum <= new_bin_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bin <= payload;
    end
  end

`ifndef NO_ASSERTIONS
  // a report always lands in the result register
  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> bin_valid)
    else $error("emit did not load result register");

  // no bin reported once the last bin is out
  a_no_emit_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !bins_done)
    else $error("bin reported after final bin");

  // done only ever set on the last bin
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    bins_done |-> is_final)
    else $error("bins_done set before last bin");
`endif

endmodule

`default_nettype wire

// ===== design/sshb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sshb_ctrl: sequencing controller
// Runs the bound division, takes items, closes bins and flushes on last item.
// ----------------------------------------------------------------------------
`default_nettype none

module sshb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           point_valid,
  output logic                point_ready,
  output sshb_pkg::cmd_t      cmd,
  input  wire sshb_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,  // kick off bin-width division
    S_DIV   = 5'b00010,  // wait for divider
    S_IDLE  = 5'b00100,  // wait for an item
    S_EVAL  = 5'b01000,  // close passed bins, then add value
    S_FLUSH = 5'b10000   // report every remaining bin
  } state_t;

  state_t state;
  state_t state_next;
  logic   active;

  always_comb begin
    state_next = state;
    cmd        = '0;
    active     = !sts.bins_done && sts.key_ge_min;
    case (state)
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.restart = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (point_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (active && sts.key_gt_high) begin
          cmd.emit = sts.slot_free;
        end else begin
          cmd.add    = active;
          state_next = sts.item_last ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.bins_done) begin
          cmd.restart = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.emit = sts.slot_free;
        end
      end
      default: state_next = S_LOAD;
    endcase
    // a register write recomputes the bounds
    if (sts.cfg_hit) begin
      state_next = S_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign point_ready = (state == S_IDLE);

`ifndef NO_ASSERTIONS
  // items are only taken with the bounds settled
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    point_ready |-> !sts.div_busy)
    else $error("item accepted while divider busy");
`endif

endmodule

`default_nettype wire

// ===== design/sorted_stream_histogram_binner_top.sv =====
// ----------------------------------------------------------------------------
// sorted_stream_histogram_binner_top: equal-width histogram of sorted keys
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we                    cfg_index, cfg_data
//   point    in         point_valid/point_ready   point (sshb_pkg::point_t)
//   bin      out        bin_valid/bin_ready       bin   (sshb_pkg::result_t)
//
// An item is accepted in S_IDLE and evaluated in S_EVAL, which reports each
// bin it closes; no new item is taken meanwhile. A last item then reports
// every remaining bin and restarts. After reset or a register write the bin
// width is divided out, one quotient bit per cycle; point_ready stays low.
// A full result register (bin_ready low) holds bin closing until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_stream_histogram_binner_top #(
  parameter int MAX_BINS = sshb_pkg::DEF_MAX_BINS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sshb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sshb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            point_valid,
  output logic                                 point_ready,
  input  wire sshb_pkg::point_t                point,
  output logic                                 bin_valid,
  input  wire logic                            bin_ready,
  output sshb_pkg::result_t                    bin
);

  sshb_pkg::cmd_t cmd;
  sshb_pkg::sts_t sts;

  sshb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  sshb_datapath #(
    .MAX_BINS(MAX_BINS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point),
    .bin_ready (bin_ready),
    .bin_valid (bin_valid),
    .bin       (bin),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ===== tb/sorted_stream_histogram_binner_top_test.sv =====
// ----------------------------------------------------------------------------
// sorted_stream_histogram_binner_top_test: self-checking bench for the binner
// Streams of (key, value) points go in with random gaps, bins come out under
// random backpressure. A behavioral copy of the histogram predicts every bin
// item, and each one is checked field by field in arrival order. Register
// settings change between streams, while the block is idle.
// ----------------------------------------------------------------------------
module sorted_stream_histogram_binner_top_test;
  import sshb_pkg::*;

  localparam int NBIN_LIMIT    = DEF_MAX_BINS;
  localparam int TARGET_POINTS = 470;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  point_valid;
  logic                  point_ready;
  point_t                point;
  logic                  bin_valid;
  logic                  bin_ready;
  result_t               bin;

  sorted_stream_histogram_binner_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point      (point),
    .bin_valid  (bin_valid),
    .bin_ready  (bin_ready),
    .bin        (bin)
  );

  // shared bench state
  result_t bins_due[$];
  int      fail_count;
  int      points_sent;
  int      hold_cycles;
  bit      no_idle;

  // histogram settings and running state of the predictor
  logic [KEY_W-1:0]   cfg_min;
  logic [KEY_W-1:0]   cfg_max;
  logic [NBINS_W-1:0] cfg_bins;
  int                 cur_bin;
  logic [KEY_W-1:0]   lo_bound;
  logic [KEY_W-1:0]   hi_bound;
  logic [SUM_W-1:0]   bin_sum;
  logic [SUM_W-1:0]   peak_sum;
  logic [SUM_W-1:0]   all_sum;
  bit                 hist_done;

  // ---------------------------------------------------------------------------
  // Histogram predictor
  // ---------------------------------------------------------------------------

  // out-of-range bin counts are clamped
  function automatic int bins_used();
    if (cfg_bins == 0) return 1;
    if (cfg_bins > NBIN_LIMIT) return NBIN_LIMIT;
    return cfg_bins;
  endfunction

  // a max below min collapses the range onto min
  function automatic logic [KEY_W-1:0] top_key();
    return (cfg_max < cfg_min) ? cfg_min : cfg_max;
  endfunction

  // min + floor(k * span / n), exact
  function automatic logic [KEY_W-1:0] bin_edge(input int k);
    logic [63:0] span;
    span = 64'(top_key() - cfg_min);
    return cfg_min + 32'((64'(k) * span) / 64'(bins_used()));
  endfunction

  function automatic void load_bounds();
    lo_bound = (cur_bin == 0) ? cfg_min : bin_edge(cur_bin);
    hi_bound = (cur_bin + 1 >= bins_used()) ? top_key() : bin_edge(cur_bin + 1);
  endfunction

  function automatic void restart_hist();
    cur_bin   = 0;
    bin_sum   = '0;
    peak_sum  = '0;
    all_sum   = '0;
    hist_done = 1'b0;
    load_bounds();
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // report the current bin and move on to the next one
  function automatic void close_bin();
    result_t r;
    bit      fin;
    fin = (cur_bin + 1 >= bins_used());
    if (bin_sum > peak_sum) peak_sum = bin_sum;
    all_sum = sat_add(all_sum, bin_sum);
    r.bin_number        = BIN_NUM_W'(cur_bin);
    r.bin_low_key       = lo_bound;
    r.bin_high_key      = hi_bound;
    r.bin_total         = bin_sum;
    r.final_bin         = fin;
    r.largest_bin_total = fin ? peak_sum : '0;
    r.grand_total       = fin ? all_sum : '0;
    bins_due.push_back(r);
    bin_sum = '0;
    if (fin) begin
      hist_done = 1'b1;
    end else begin
      cur_bin++;
      load_bounds();
    end
  endfunction

  // one accepted point: close passed bins, accumulate, flush on last
  function automatic void hist_take_point(input point_t p);
    if (!hist_done && p.point_key >= cfg_min) begin
      while (!hist_done && p.point_key > hi_bound) close_bin();
      if (!hist_done) bin_sum = sat_add(bin_sum, SUM_W'(p.point_value));
    end
    if (p.last_point) begin
      while (!hist_done) close_bin();
      restart_hist();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit, error reporting
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("sorted_stream_histogram_binner_top_test: FAIL");
    $finish;
  end

  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got)
      note_error($sformatf("%s: expected %0h, got %0h", field, want, got));
  endtask

  // ---------------------------------------------------------------------------
  // Bin receiver: random stalls per item, plus a long hold on request
  // ---------------------------------------------------------------------------
  initial begin : bin_sink
    int wait_left;
    wait_left = 0;
    bin_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (bin_valid && bin_ready) wait_left = no_idle ? 0 : $urandom_range(0, 7);
      if (hold_cycles > 0) begin
        hold_cycles--;
        bin_ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        bin_ready <= 1'b0;
      end else begin
        bin_ready <= 1'b1;
      end
    end
  end

  // compare every accepted bin item with the oldest prediction
  always @(posedge clk) begin : bin_checker
    result_t want;
    if (!rst && bin_valid && bin_ready) begin
      if (bins_due.size() == 0) begin
        note_error($sformatf("unexpected bin item, bin_number %0d", bin.bin_number));
      end else begin
        want = bins_due.pop_front();
        check_field("bin_number", want.bin_number, bin.bin_number);
        check_field("bin_low_key", want.bin_low_key, bin.bin_low_key);
        check_field("bin_high_key", want.bin_high_key, bin.bin_high_key);
        check_field("bin_total", want.bin_total, bin.bin_total);
        check_field("final_bin", want.final_bin, bin.final_bin);
        check_field("largest_bin_total", want.largest_bin_total, bin.largest_bin_total);
        check_field("grand_total", want.grand_total, bin.grand_total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // drop valid, drain all bins, then let any result-free work finish
  task automatic wait_idle();
    point_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_KEY:  cfg_min = data;
      REG_MAX_KEY:  cfg_max = data;
      REG_NUM_BINS: cfg_bins = data[NBINS_W-1:0];
      default:      return;
    endcase
    restart_hist();
  endtask

  task automatic set_range(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                           input logic [CFG_DATA_W-1:0] nbins);
    write_reg(REG_MIN_KEY, lo);
    write_reg(REG_MAX_KEY, hi);
    write_reg(REG_NUM_BINS, nbins);
  endtask

  task automatic send_point(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value,
                            input bit last);
    int     gap;
    point_t p;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.point_key   = key;
    p.point_value = value;
    p.last_point  = last;
    point       <= p;
    point_valid <= 1'b1;
    @(posedge clk);
    while (!point_ready) @(posedge clk);
    hist_take_point(p);
    points_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // mostly in range, some below, above, on a bin edge, or anywhere
  function automatic logic [KEY_W-1:0] draw_key();
    logic [KEY_W-1:0] top;
    top = top_key();
    case ($urandom_range(0, 19))
      0:       return (cfg_min == 0) ? cfg_min : $urandom_range(0, cfg_min - 1);
      1:       return (top == '1) ? top : $urandom_range(top + 1, 32'hFFFF_FFFF);
      2:       return bin_edge($urandom_range(0, bins_used()));
      3:       return $urandom;
      default: return $urandom_range(cfg_min, top);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 3))
      0:       return '1;
      1:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_random_config();
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [NBINS_W-1:0] n;
    case ($urandom_range(0, 9))
      0:       n = '0;
      1:       n = NBINS_W'(NBIN_LIMIT);
      2:       n = NBINS_W'($urandom_range(NBIN_LIMIT + 1, 127));
      3:       n = NBINS_W'($urandom_range(9, NBIN_LIMIT));
      default: n = NBINS_W'($urandom_range(1, 8));
    endcase
    lo = $urandom;
    case ($urandom_range(0, 5))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        // small span, up to 12 above min: bins may share bounds
        hi = lo + $urandom_range(0, 12);
        if (hi < lo) hi = '1;
      end
      2: hi = $urandom_range(0, lo);
      3: begin
        a  = $urandom;
        b  = $urandom;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      default: begin
        hi = lo + $urandom_range(0, 1 << 20);
        if (hi < lo) hi = '1;
      end
    endcase
    set_range(lo, hi, {25'($urandom), n});
  endtask

  // a sorted stream closed by a last point, or an unsorted noisy one
  task automatic send_stream(input bit noise);
    logic [KEY_W-1:0] keys[$];
    int               len;
    bit               last;
    len = $urandom_range(1, 12);
    repeat (len) keys.push_back(draw_key());
    if (!noise) keys.sort();
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) last = noise ? bit'($urandom_range(0, 1)) : 1'b1;
      else last = noise && ($urandom_range(0, 15) == 0);
      send_point(keys[i], draw_value(), last);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset settings: 64 bins over the whole key space
  task automatic test_default_range();
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0400_0000, 32'h0000_0001, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h5555_AAAA, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hAAAA_5555, 1'b1);
  endtask

  // one bin, zero bins, and a count above the limit
  task automatic test_bin_count_limits();
    set_range(32'd100, 32'd200, 32'd1);
    send_point(32'd50, 32'd3, 1'b0);
    send_point(32'd100, 32'd4, 1'b0);
    send_point(32'd200, 32'd5, 1'b1);
    write_reg(REG_NUM_BINS, 32'd0);
    send_point(32'd150, 32'd6, 1'b0);
    send_point(32'd300, 32'd7, 1'b1);
    set_range(32'd0, 32'd639, 32'hFFFF_FFFF);
    send_point(32'd5, 32'd8, 1'b0);
    send_point(32'd639, 32'd9, 1'b1);
  endtask

  // max below min, keys below and above the range, last after all bins done
  task automatic test_key_range_cases();
    set_range(32'd1000, 32'd10, 32'd4);
    send_point(32'd999, 32'd1, 1'b0);
    send_point(32'd1000, 32'd7, 1'b0);
    send_point(32'd1001, 32'd2, 1'b0);
    send_point(32'd2000, 32'd3, 1'b1);
  endtask

  // shared bounds, unsorted keys, write to an unused register index
  task automatic test_bin_bounds_cases();
    set_range(32'd10, 32'd13, 32'd8);
    send_point(32'd10, 32'd1, 1'b0);
    send_point(32'd11, 32'd2, 1'b0);
    send_point(32'd12, 32'd3, 1'b0);
    send_point(32'd13, 32'd4, 1'b1);
    set_range(32'd0, 32'd399, 32'd4);
    send_point(32'd250, 32'd10, 1'b0);
    send_point(32'd50, 32'd20, 1'b0);
    send_point(32'd399, 32'd30, 1'b1);
    write_reg(REG_UNUSED, $urandom);
    send_point(32'd200, 32'd9, 1'b1);
  endtask

  // receiver holds off while points keep coming, so the input stalls
  task automatic test_output_stall();
    set_range(32'h0000_0000, 32'hFFFF_FFFF, 32'd64);
    no_idle     = 1'b1;
    hold_cycles = 300;
    for (int i = 0; i < 10; i++)
      send_point(32'(i) * 32'h1900_0000 + $urandom_range(0, 32'h00FF_FFFF),
                 $urandom, i == 9);
    no_idle = 1'b0;
  endtask

  task automatic test_random_streams();
    while (points_sent < TARGET_POINTS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick_random_config();
      repeat ($urandom_range(1, 3)) send_stream($urandom_range(0, 7) == 0);
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count  = 0;
    points_sent = 0;
    hold_cycles = 0;
    no_idle     = 1'b0;
    cfg_min     = MIN_KEY_RST;
    cfg_max     = MAX_KEY_RST;
    cfg_bins    = NUM_BINS_RST;
    restart_hist();
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    point_valid <= 1'b0;
    point       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_default_range();
    test_bin_count_limits();
    test_key_range_cases();
    test_bin_bounds_cases();
    test_output_stall();
    test_random_streams();

    // drain and let the block settle
    point_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && bins_due.size() == 0) begin
      $display("sorted_stream_histogram_binner_top_test: PASS");
    end else begin
      $display("sorted_stream_histogram_binner_top_test: FAIL");
    end
    $finish;
  end

endmodule
